// File: hdl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is active
`define RMT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define RMT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/rmt_pkg.sv
`default_nettype none

package rmt_pkg;

  // table sizing
  localparam int NUM_MUTEXES    = 16;
  localparam int QUEUE_DEPTH    = 64;
  localparam int THREAD_ID_BITS = 8;
  localparam int COUNT_BITS     = 16;

  // port field widths
  localparam int CMD_W = 3;
  localparam int SEL_W = 5;
  localparam int TID_W = 8;

  // derived widths
  localparam int MUTEX_IDX_W = $clog2(NUM_MUTEXES);
  localparam int ALLOC_W     = $clog2(NUM_MUTEXES + 1);
  localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int WCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH   = NUM_MUTEXES * QUEUE_DEPTH;
  localparam int MEM_AW      = MUTEX_IDX_W + Q_IDX_W;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // request queue between front and back
  localparam int QUEUE_SLOTS = 2;
  localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
  localparam int SLOT_CNT_W  = $clog2(QUEUE_SLOTS + 1);

  // command codes
  localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOCK    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TRYLOCK = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNLOCK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd4;

  // classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_ERROR,
    OP_CREATE,
    OP_LOCK,
    OP_TRYLOCK,
    OP_UNLOCK,
    OP_DESTROY
  } op_kind_e;

  typedef struct packed {
    op_kind_e                   kind;
    logic [MUTEX_IDX_W-1:0]     idx;
    logic [THREAD_ID_BITS-1:0]  tid;
    logic [SEL_W-1:0]           new_id;
  } op_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } q_stat_t;

endpackage

`default_nettype wire

// File: hdl/rmt_front.sv
`default_nettype none

module rmt_front import rmt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic [CMD_W-1:0]  cmd_i,
  input  wire logic [SEL_W-1:0]  mutex_sel_i,
  input  wire logic [TID_W-1:0]  thread_id_i,
  input  wire q_stat_t           q_stat_i,
  output      logic              push_valid_o,
  output      op_t               push_op_o
);

  logic [ALLOC_W-1:0] alloc_q, alloc_d;
  logic               sel_ok;
  logic               table_full;
  logic               accept;

  assign in_ready_o   = q_stat_i.not_full;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = accept;

  assign sel_ok     = (mutex_sel_i != '0) && (32'(mutex_sel_i) <= 32'(alloc_q));
  assign table_full = (32'(alloc_q) >= NUM_MUTEXES);

  // classify the request
  always_comb begin
    push_op_o.kind   = OP_ERROR;
    push_op_o.idx    = MUTEX_IDX_W'(mutex_sel_i - SEL_W'(1));
    push_op_o.tid    = thread_id_i[THREAD_ID_BITS-1:0];
    push_op_o.new_id = '0;
    alloc_d          = alloc_q;
    case (cmd_i)
      CMD_CREATE: begin
        if (!table_full) begin
          push_op_o.kind   = OP_CREATE;
          push_op_o.new_id = SEL_W'(alloc_q + ALLOC_W'(1));
          alloc_d          = alloc_q + ALLOC_W'(1);
        end
      end
      CMD_LOCK:    if (sel_ok) push_op_o.kind = OP_LOCK;
      CMD_TRYLOCK: if (sel_ok) push_op_o.kind = OP_TRYLOCK;
      CMD_UNLOCK:  if (sel_ok) push_op_o.kind = OP_UNLOCK;
      CMD_DESTROY: if (sel_ok) push_op_o.kind = OP_DESTROY;
      default:     push_op_o.kind = OP_ERROR;
    endcase
  end

  // allocation counter, only moves on an accepted create
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q <= '0;
    end else if (accept) begin
      alloc_q <= alloc_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rmt_queue.sv
`default_nettype none

module rmt_queue import rmt_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_valid_i,
  input  wire op_t     push_op_i,
  input  wire logic    pop_ready_i,
  output      op_t     pop_op_o,
  output      q_stat_t stat_o
);

  op_t                   slots_q [QUEUE_SLOTS];
  logic [SLOT_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [SLOT_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign stat_o.not_empty = (cnt_q != '0);
  assign stat_o.not_full  = (32'(cnt_q) < QUEUE_SLOTS);
  assign do_push          = push_valid_i && stat_o.not_full;
  assign do_pop           = pop_ready_i && stat_o.not_empty;
  assign pop_op_o         = slots_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_SLOTS - 1) ? '0 : wr_ptr_q + SLOT_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_SLOTS - 1) ? '0 : rd_ptr_q + SLOT_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + SLOT_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - SLOT_CNT_W'(1);
      end
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rmt_back.sv
`default_nettype none

module rmt_back import rmt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire q_stat_t          q_stat_i,
  input  wire op_t              op_i,
  output      logic             pop_ready_o,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic             status_o,
  output      logic [SEL_W-1:0] new_mutex_id_o
);

  // per-mutex table
  logic                      locked_q [NUM_MUTEXES];
  logic [THREAD_ID_BITS-1:0] owner_q  [NUM_MUTEXES];
  logic [COUNT_BITS-1:0]     cnt_q    [NUM_MUTEXES];
  logic [WCNT_W-1:0]         wcnt_q   [NUM_MUTEXES];
  logic [Q_IDX_W-1:0]        head_q   [NUM_MUTEXES];

  // waiting thread ids, one ring per mutex
  logic [THREAD_ID_BITS-1:0] waiter_mem [MEM_DEPTH];

  logic                      out_valid_q;
  logic                      status_q, status_d;
  logic [SEL_W-1:0]          new_id_q, new_id_d;

  logic                      fire;
  logic                      e_locked, n_locked;
  logic [THREAD_ID_BITS-1:0] e_owner, n_owner;
  logic [COUNT_BITS-1:0]     e_cnt, n_cnt, cnt_dec;
  logic [WCNT_W-1:0]         e_wcnt, n_wcnt;
  logic [Q_IDX_W-1:0]        e_head, n_head;
  logic                      owner_hit;
  logic                      mem_we;
  logic [Q_IDX_W-1:0]        tail_pos;

  assign pop_ready_o    = !out_valid_q || out_ready_i;
  assign fire           = pop_ready_o && q_stat_i.not_empty;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign new_mutex_id_o = new_id_q;

  assign e_locked  = locked_q[op_i.idx];
  assign e_owner   = owner_q[op_i.idx];
  assign e_cnt     = cnt_q[op_i.idx];
  assign e_wcnt    = wcnt_q[op_i.idx];
  assign e_head    = head_q[op_i.idx];
  assign owner_hit = e_locked && (e_owner == op_i.tid);
  assign cnt_dec   = (e_cnt != '0) ? e_cnt - COUNT_BITS'(1) : '0;
  // ring index wraps at the queue depth
  assign tail_pos  = e_head + Q_IDX_W'(e_wcnt);

  // execute one request on the selected entry
  always_comb begin
    n_locked = e_locked;
    n_owner  = e_owner;
    n_cnt    = e_cnt;
    n_wcnt   = e_wcnt;
    n_head   = e_head;
    mem_we   = 1'b0;
    status_d = 1'b1;
    new_id_d = '0;
    case (op_i.kind)
      OP_CREATE: begin
        status_d = 1'b0;
        new_id_d = op_i.new_id;
      end
      OP_LOCK, OP_TRYLOCK: begin
        if (!e_locked) begin
          n_locked = 1'b1;
          n_owner  = op_i.tid;
          n_cnt    = COUNT_BITS'(1);
          status_d = 1'b0;
        end else if (owner_hit) begin
          if (e_cnt != CNT_MAX) begin
            n_cnt    = e_cnt + COUNT_BITS'(1);
            status_d = 1'b0;
          end
        end else if ((op_i.kind == OP_LOCK) && (32'(e_wcnt) < QUEUE_DEPTH)) begin
          mem_we = 1'b1;
          n_wcnt = e_wcnt + WCNT_W'(1);
        end
      end
      OP_UNLOCK: begin
        if (owner_hit) begin
          status_d = 1'b0;
          n_cnt    = cnt_dec;
          if (cnt_dec == '0) begin
            n_locked = 1'b0;
            n_owner  = '0;
            if (e_wcnt != '0) begin
              n_head = e_head + Q_IDX_W'(1);
              n_wcnt = e_wcnt - WCNT_W'(1);
            end
          end
        end
      end
      OP_DESTROY: begin
        status_d = e_locked || (e_wcnt != '0);
      end
      default: begin
        status_d = 1'b1;
      end
    endcase
  end

  // table write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MUTEXES; i++) begin
        locked_q[i] <= 1'b0;
        owner_q[i]  <= '0;
        cnt_q[i]    <= '0;
        wcnt_q[i]   <= '0;
        head_q[i]   <= '0;
      end
    end else if (fire) begin
      locked_q[op_i.idx] <= n_locked;
      owner_q[op_i.idx]  <= n_owner;
      cnt_q[op_i.idx]    <= n_cnt;
      wcnt_q[op_i.idx]   <= n_wcnt;
      head_q[op_i.idx]   <= n_head;
    end
  end

  // waiter ring write
  always_ff @(posedge clk_i) begin
    if (fire && mem_we) begin
      waiter_mem[{op_i.idx, tail_pos}] <= op_i.tid;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      new_id_q <= new_id_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/recursive_mutex_table.sv
// path: an accepted request is written into the request queue, then executed by the back end into the result register
// throughput: one request per cycle; the front stalls only when the two-slot
//   request queue is full, which happens while the result register is held
// reset: asynchronous active-low; clears the allocation count, all mutex
//   entries and the queue; the waiter store needs no clearing
`default_nettype none

`include "assert_macros.svh"

module recursive_mutex_table import rmt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [CMD_W-1:0] cmd_i,
  input  wire logic [SEL_W-1:0] mutex_sel_i,
  input  wire logic [TID_W-1:0] thread_id_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic             status_o,
  output      logic [SEL_W-1:0] new_mutex_id_o
);

  q_stat_t q_stat;
  logic    push_valid;
  op_t     push_op;
  op_t     pop_op;
  logic    pop_ready;

  // classify requests and hand out ids
  rmt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .mutex_sel_i  (mutex_sel_i),
    .thread_id_i  (thread_id_i),
    .q_stat_i     (q_stat),
    .push_valid_o (push_valid),
    .push_op_o    (push_op)
  );

  // decoupling queue
  rmt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_op_i    (push_op),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op),
    .stat_o       (q_stat)
  );

  // mutex table execution
  rmt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .op_i           (pop_op),
    .pop_ready_o    (pop_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .new_mutex_id_o (new_mutex_id_o)
  );

  // an accepted request is queued by the next cycle
  `RMT_ASSERT(a_push_lands, clk_i, rst_ni, in_valid_i && in_ready_o |=> q_stat.not_empty, "accepted request missing from queue")
  // a result only appears after the queue held a request
  `RMT_ASSERT(a_out_from_queue, clk_i, rst_ni, $rose(out_valid_o) |-> $past(q_stat.not_empty), "result without queued request")
  // with the queue empty a taken result is not replaced
  `RMT_ASSERT(a_no_phantom, clk_i, rst_ni, out_valid_o && out_ready_i && !q_stat.not_empty |=> !out_valid_o, "result invented from empty queue")
  // the queue never refuses input while it is empty
  `RMT_ASSERT_ALWAYS(a_empty_ready, clk_i, !rst_ni || q_stat.not_empty || in_ready_o, "empty queue stalls input")

endmodule

`default_nettype wire
